/* rtl/lme_pkg.sv */
// ----------------------------------------------------------------------------
// lme_pkg
// Shared types and constants for the LEA micro-op expander: micro-op kinds,
// microcode control word layout and program entry addresses.
// ----------------------------------------------------------------------------
package lme_pkg;

  typedef enum logic [2:0] {
    UOP_MOV_REG = 3'd0,
    UOP_MOV_IMM = 3'd1,
    UOP_ADD_REG = 3'd2,
    UOP_ADD_IMM = 3'd3,
    UOP_SHL_IMM = 3'd4,
    UOP_MUL_IMM = 3'd5
  } uop_kind_t;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_BASE  = 2'd1,
    SRC_INDEX = 2'd2,
    SRC_DEST  = 2'd3
  } src_sel_t;

  typedef enum logic [1:0] {
    IMM_ZERO  = 2'd0,
    IMM_SCALE = 2'd1,
    IMM_MUL   = 2'd2,
    IMM_DISP  = 2'd3
  } imm_sel_t;

  // emit condition of a microcode step
  typedef enum logic [3:0] {
    C_ALWAYS    = 4'd0,
    C_D_NE_B    = 4'd1,
    C_D_NE_X    = 4'd2,
    C_SCALE     = 4'd3,
    C_HAS_BASE  = 4'd4,
    C_HAS_INDEX = 4'd5,
    C_MUL_W     = 4'd6,
    C_ADD_W     = 4'd7,
    C_DISP      = 4'd8,
    C_NONE_YET  = 4'd9
  } cond_t;

  localparam int PC_W = 4;

  typedef struct packed {
    uop_kind_t kind;
    src_sel_t  src;
    imm_sel_t  imm;
    cond_t     cond;
    logic      rpt;   // repeat 2^scale times while the condition holds
    logic      jmp;   // continue at the common tail
    logic      fin;   // last step of the program
  } ctrl_t;

  typedef struct packed {
    uop_kind_t   kind;
    logic [3:0]  dest;
    logic [3:0]  src;
    logic [31:0] imm;
  } uop_t;

  // program entry points
  localparam logic [PC_W-1:0] ENT_W_IDX_DST  = 4'd0;
  localparam logic [PC_W-1:0] ENT_W_BASE     = 4'd2;
  localparam logic [PC_W-1:0] ENT_W_INDEX    = 4'd5;
  localparam logic [PC_W-1:0] ENT_DISP_ONLY  = 4'd7;
  localparam logic [PC_W-1:0] ENT_N_ALL_SAME = 4'd8;
  localparam logic [PC_W-1:0] ENT_N_BASE     = 4'd9;
  localparam logic [PC_W-1:0] ENT_N_INDEX    = 4'd11;
  localparam logic [PC_W-1:0] ENT_TAIL       = 4'd14;

  localparam logic [3:0] REG_LIMIT = 4'd10;

endpackage

/* rtl/lme_ucode_rom.sv */
// ----------------------------------------------------------------------------
// lme_ucode_rom
// Microcode program store: one control word per step address.
// ----------------------------------------------------------------------------
module lme_ucode_rom (
  input  logic [lme_pkg::PC_W-1:0] pc,
  output lme_pkg::ctrl_t           word
);

  always_comb begin
    case (pc)
      // 64-bit, index is dest, base differs: shift then add base
      4'd0:  word = '{lme_pkg::UOP_SHL_IMM, lme_pkg::SRC_ZERO,  lme_pkg::IMM_SCALE,
                      lme_pkg::C_SCALE,    1'b0, 1'b0, 1'b0};
      4'd1:  word = '{lme_pkg::UOP_ADD_REG, lme_pkg::SRC_BASE,  lme_pkg::IMM_ZERO,
                      lme_pkg::C_ALWAYS,   1'b0, 1'b1, 1'b0};
      // 64-bit with base
      4'd2:  word = '{lme_pkg::UOP_MOV_REG, lme_pkg::SRC_BASE,  lme_pkg::IMM_ZERO,
                      lme_pkg::C_D_NE_B,   1'b0, 1'b0, 1'b0};
      4'd3:  word = '{lme_pkg::UOP_MUL_IMM, lme_pkg::SRC_ZERO,  lme_pkg::IMM_MUL,
                      lme_pkg::C_MUL_W,    1'b0, 1'b0, 1'b0};
      4'd4:  word = '{lme_pkg::UOP_ADD_REG, lme_pkg::SRC_INDEX, lme_pkg::IMM_ZERO,
                      lme_pkg::C_ADD_W,    1'b1, 1'b1, 1'b0};
      // 64-bit index only
      4'd5:  word = '{lme_pkg::UOP_MOV_REG, lme_pkg::SRC_INDEX, lme_pkg::IMM_ZERO,
                      lme_pkg::C_D_NE_X,   1'b0, 1'b0, 1'b0};
      4'd6:  word = '{lme_pkg::UOP_SHL_IMM, lme_pkg::SRC_ZERO,  lme_pkg::IMM_SCALE,
                      lme_pkg::C_SCALE,    1'b0, 1'b1, 1'b0};
      // displacement only, either width
      4'd7:  word = '{lme_pkg::UOP_MOV_IMM, lme_pkg::SRC_ZERO,  lme_pkg::IMM_DISP,
                      lme_pkg::C_ALWAYS,   1'b0, 1'b1, 1'b0};
      // 32-bit, base, index and dest all the same
      4'd8:  word = '{lme_pkg::UOP_MUL_IMM, lme_pkg::SRC_ZERO,  lme_pkg::IMM_MUL,
                      lme_pkg::C_ALWAYS,   1'b0, 1'b1, 1'b0};
      // 32-bit with base
      4'd9:  word = '{lme_pkg::UOP_MOV_REG, lme_pkg::SRC_BASE,  lme_pkg::IMM_ZERO,
                      lme_pkg::C_D_NE_B,   1'b0, 1'b0, 1'b0};
      4'd10: word = '{lme_pkg::UOP_ADD_REG, lme_pkg::SRC_INDEX, lme_pkg::IMM_ZERO,
                      lme_pkg::C_HAS_INDEX, 1'b1, 1'b1, 1'b0};
      // 32-bit index path
      4'd11: word = '{lme_pkg::UOP_MOV_REG, lme_pkg::SRC_INDEX, lme_pkg::IMM_ZERO,
                      lme_pkg::C_D_NE_X,   1'b0, 1'b0, 1'b0};
      4'd12: word = '{lme_pkg::UOP_SHL_IMM, lme_pkg::SRC_ZERO,  lme_pkg::IMM_SCALE,
                      lme_pkg::C_SCALE,    1'b0, 1'b0, 1'b0};
      4'd13: word = '{lme_pkg::UOP_ADD_REG, lme_pkg::SRC_BASE,  lme_pkg::IMM_ZERO,
                      lme_pkg::C_HAS_BASE, 1'b0, 1'b0, 1'b0};
      // common tail: displacement add, then mov-to-self if nothing came out
      4'd14: word = '{lme_pkg::UOP_ADD_IMM, lme_pkg::SRC_ZERO,  lme_pkg::IMM_DISP,
                      lme_pkg::C_DISP,     1'b0, 1'b0, 1'b0};
      default: word = '{lme_pkg::UOP_MOV_REG, lme_pkg::SRC_DEST, lme_pkg::IMM_ZERO,
                      lme_pkg::C_NONE_YET, 1'b0, 1'b0, 1'b1};
    endcase
  end

endmodule

/* rtl/lea_micro_op_expander_core.sv */
// ----------------------------------------------------------------------------
// lea_micro_op_expander_core
// Expands one packed LEA request into a run of simple ALU micro-ops.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one request: s_tdata is the 64-bit packed payload,
//   s_tuser the width select (0 = 32-bit, 1 = 64-bit). Master side returns
//   one to ten micro-ops per request; m_tlast marks the final one of a
//   request and m_tuser flags the single result of a malformed request.
//   A request is checked in the cycle it is taken; a bad one goes through an
//   error state that registers its error result. A good one walks the
//   16-step microcode store, one step per cycle unless the output stalls:
//   3 to 5 steps plus up to 7 extra passes of the index-add loop. The newest
//   micro-op waits in a hold register until another follows or the program
//   ends, so m_tlast is known when it goes out. One request is in work at a
//   time; s_tready is high again in the cycle the last micro-op shows on the
//   master side, so the next request can be taken while that result waits.
//   A stall on m_tready freezes the sequencer; nothing is dropped.
//   Reset (rst, synchronous) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module lea_micro_op_expander_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // payload
  input  logic        s_tuser,   // width select (0 = 32-bit, 1 = 64-bit)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // uop_kind, dest_reg, source_reg, immediate, is_wide
  output logic        m_tuser,   // is_error
  output logic        m_tlast    // is_last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_ERR  = 3'b100
  } state_t;

  state_t state;

  logic [lme_pkg::PC_W-1:0] pc;
  logic [2:0]  rep;
  logic [3:0]  d, b, x;
  logic [1:0]  sc;
  logic        hx, hb, wide;
  logic [31:0] disp;

  lme_pkg::uop_t hold;
  logic          hold_valid;
  lme_pkg::uop_t out_uop;
  logic          out_wide, out_err, out_last;

  lme_pkg::ctrl_t word;
  lme_pkg::uop_t  uop_next;
  logic           emit;
  logic           adv;
  logic           rep_done;
  logic [3:0]     n;
  logic           out_load;

  // request fields
  logic [3:0] in_d, in_b, in_x;
  logic [1:0] in_sc;
  logic       in_hx, in_hb, in_bad;
  logic [lme_pkg::PC_W-1:0] entry;

  assign in_d  = s_tdata[3:0];
  assign in_b  = s_tdata[7:4];
  assign in_x  = s_tdata[11:8];
  assign in_sc = s_tdata[13:12];
  assign in_hx = s_tdata[14];
  assign in_hb = s_tdata[15];

  always_comb begin
    in_bad = (s_tdata[63:48] != 16'd0) || (in_d > lme_pkg::REG_LIMIT);
    if (in_hb ? (in_b > lme_pkg::REG_LIMIT) : (in_b != 4'd0)) in_bad = 1'b1;
    if (in_hx ? (in_x > lme_pkg::REG_LIMIT) : (in_x != 4'd0 || in_sc != 2'd0)) in_bad = 1'b1;
  end

  // program selection follows the separate 64-bit and 32-bit aliasing rules
  always_comb begin
    if (s_tuser) begin
      if (in_hb && in_hx && in_d == in_x && in_d != in_b) entry = lme_pkg::ENT_W_IDX_DST;
      else if (in_hb)                                     entry = lme_pkg::ENT_W_BASE;
      else if (in_hx)                                     entry = lme_pkg::ENT_W_INDEX;
      else                                                entry = lme_pkg::ENT_DISP_ONLY;
    end else begin
      if (in_hb && in_hx && in_d == in_b && in_d == in_x) entry = lme_pkg::ENT_N_ALL_SAME;
      else if (in_hb && (!in_hx || in_d != in_x))         entry = lme_pkg::ENT_N_BASE;
      else if (in_hx)                                     entry = lme_pkg::ENT_N_INDEX;
      else                                                entry = lme_pkg::ENT_DISP_ONLY;
    end
  end

  lme_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  assign n        = 4'd1 << sc;
  assign rep_done = (rep == 3'(n - 4'd1));
  assign adv      = !m_tvalid || m_tready;

  always_comb begin
    case (word.cond)
      lme_pkg::C_ALWAYS:    emit = 1'b1;
      lme_pkg::C_D_NE_B:    emit = (d != b);
      lme_pkg::C_D_NE_X:    emit = (d != x);
      lme_pkg::C_SCALE:     emit = (sc != 2'd0);
      lme_pkg::C_HAS_BASE:  emit = hb;
      lme_pkg::C_HAS_INDEX: emit = hx;
      lme_pkg::C_MUL_W:     emit = hx && (d == x) && (sc != 2'd0);
      lme_pkg::C_ADD_W:     emit = hx && !((d == x) && (sc != 2'd0));
      lme_pkg::C_DISP:      emit = (disp != 32'd0) && (hb || hx);
      lme_pkg::C_NONE_YET:  emit = !hold_valid;
      default:              emit = 1'b0;
    endcase
  end

  always_comb begin
    uop_next.kind = word.kind;
    uop_next.dest = d;
    case (word.src)
      lme_pkg::SRC_BASE:  uop_next.src = b;
      lme_pkg::SRC_INDEX: uop_next.src = x;
      lme_pkg::SRC_DEST:  uop_next.src = d;
      default:            uop_next.src = 4'd0;
    endcase
    case (word.imm)
      lme_pkg::IMM_SCALE: uop_next.imm = {30'd0, sc};
      lme_pkg::IMM_MUL:   uop_next.imm = {28'd0, n} + 32'd1;
      lme_pkg::IMM_DISP:  uop_next.imm = disp;
      default:            uop_next.imm = 32'd0;
    endcase
  end

  // output register takes a new result this cycle
  assign out_load = adv && ((state == ST_ERR) ||
                            ((state == ST_RUN) && (word.fin || (emit && hold_valid))));

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= '0;
      rep        <= '0;
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            d          <= in_d;
            b          <= in_b;
            x          <= in_x;
            sc         <= in_sc;
            hx         <= in_hx;
            hb         <= in_hb;
            disp       <= s_tdata[47:16];
            wide       <= s_tuser;
            pc         <= entry;
            rep        <= '0;
            hold_valid <= 1'b0;
            state      <= in_bad ? ST_ERR : ST_RUN;
          end
        end
        ST_ERR: begin
          if (adv) begin
            out_uop  <= '0;
            out_wide <= 1'b0;
            out_err  <= 1'b1;
            out_last <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (word.fin) begin
              out_uop    <= emit ? uop_next : hold;
              out_wide   <= wide;
              out_err    <= 1'b0;
              out_last   <= 1'b1;
              hold_valid <= 1'b0;
              state      <= ST_IDLE;
            end else begin
              if (emit) begin
                // release the previous micro-op now that another follows it
                if (hold_valid) begin
                  out_uop  <= hold;
                  out_wide <= wide;
                  out_err  <= 1'b0;
                  out_last <= 1'b0;
                end
                hold       <= uop_next;
                hold_valid <= 1'b1;
              end
              if (word.rpt && emit && !rep_done) begin
                rep <= rep + 3'd1;
              end else begin
                rep <= '0;
                pc  <= word.jmp ? lme_pkg::ENT_TAIL : pc + 4'd1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'd0, out_wide, out_uop.imm, out_uop.src, out_uop.dest, out_uop.kind};
  assign m_tuser = out_err;
  assign m_tlast = out_last;

endmodule

/* rtl/lme_checker.sv */
// ----------------------------------------------------------------------------
// lme_checker
// Port-level checks for the LEA micro-op expander, bound to the top level.
// ----------------------------------------------------------------------------
module lme_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result changed while stalled");

  // error result is alone and carries no micro-op
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 48'd0))
    else $error("malformed error result");

  // a run still in flight keeps the request side closed
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("request taken in the middle of a run");

  // a taken request closes the request side in the cycle after it
  a_take_closes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request side stayed open after a request");

  // only defined micro-op kinds come out
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd6) && (m_tdata[2:0] != 3'd7))
    else $error("undefined micro-op kind");

endmodule

bind lea_micro_op_expander_core lme_checker u_lme_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
